// ===== rtl/core/bcr_pkg.sv =====
// bcr_pkg: shared constants for the midpoint circle rasterizer.
// Holds default widths, request kinds, pixel colors and decision terms.
// No dependencies.
package bcr_pkg;

    localparam int RADIUS_BITS_DEF = 10;
    localparam int COORD_BITS_DEF  = 11;
    localparam int QUEUE_DEPTH     = 2;
    localparam int PIX_PER_POS     = 8;

    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    localparam logic [1:0] COLOR_WHITE = 2'd0;
    localparam logic [1:0] COLOR_GREEN = 2'd1;
    localparam logic [1:0] COLOR_RED   = 2'd2;
    localparam logic [1:0] COLOR_BLUE  = 2'd3;

    localparam int DEC_INIT  = 3;
    localparam int DEC_DIAG  = 10;
    localparam int DEC_AXIAL = 6;

    localparam logic [1:0] COLOR_LUT [PIX_PER_POS] = '{
        COLOR_WHITE, COLOR_GREEN, COLOR_GREEN, COLOR_WHITE,
        COLOR_RED,   COLOR_BLUE,  COLOR_BLUE,  COLOR_RED
    };

endpackage

// ===== rtl/core/bcr_front.sv =====
// bcr_front: takes requests, keeps circle state, runs one midpoint step.
// Pushes one position record per productive request into the queue.
// Depends on bcr_pkg.
module bcr_front #(
    parameter int RADIUS_BITS = bcr_pkg::RADIUS_BITS_DEF,
    parameter int COORD_BITS  = bcr_pkg::COORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_kind,
    input  logic [COORD_BITS-1:0]  i_center_x,
    input  logic [COORD_BITS-1:0]  i_center_y,
    input  logic [RADIUS_BITS-1:0] i_radius,
    input  logic                   i_space,
    output logic                   o_push,
    output logic [COORD_BITS-1:0]  o_cx,
    output logic [COORD_BITS-1:0]  o_cy,
    output logic [RADIUS_BITS-1:0] o_x,
    output logic [RADIUS_BITS-1:0] o_y,
    output logic                   o_done
);
    localparam int DW = RADIUS_BITS + 4;
    localparam int CW = RADIUS_BITS + 2;

    logic [COORD_BITS-1:0]  r_cx, r_cy;
    logic [RADIUS_BITS-1:0] r_x, r_y;
    logic signed [DW-1:0]   r_d;
    logic                   r_active;

    logic [COORD_BITS-1:0]  n_cx, n_cy;
    logic [RADIUS_BITS-1:0] n_x, n_y, x1, y1;
    logic signed [DW-1:0]   n_d, diff, d_init;
    logic                   dpos, n_dpos, is_start, accept;
    logic [CW-1:0]          lhs, rhs;

    always_comb begin
        is_start = (i_kind == bcr_pkg::KIND_START);
        dpos     = (r_d > $signed(DW'(0)));
        x1       = r_x + RADIUS_BITS'(1);
        y1       = dpos ? (r_y - RADIUS_BITS'(1)) : r_y;
        diff     = $signed({{(DW-RADIUS_BITS){1'b0}}, x1})
                 - (dpos ? $signed({{(DW-RADIUS_BITS){1'b0}}, y1}) : $signed(DW'(0)));
        d_init   = $signed(DW'(bcr_pkg::DEC_INIT))
                 - $signed({{(DW-RADIUS_BITS-1){1'b0}}, i_radius, 1'b0});
        if (is_start) begin
            n_cx = i_center_x;
            n_cy = i_center_y;
            n_x  = '0;
            n_y  = i_radius;
            n_d  = d_init;
        end else begin
            n_cx = r_cx;
            n_cy = r_cy;
            n_x  = x1;
            n_y  = y1;
            n_d  = r_d + (diff <<< 2)
                 + (dpos ? $signed(DW'(bcr_pkg::DEC_DIAG)) : $signed(DW'(bcr_pkg::DEC_AXIAL)));
        end
        n_dpos = (n_d > $signed(DW'(0)));
        lhs    = {2'b00, n_x} + CW'(1) + CW'(n_dpos);
        rhs    = {2'b00, n_y};
        o_done = (lhs > rhs);
        o_ready = i_space;
        accept  = i_valid && i_space;
        o_push  = accept && (is_start || r_active);
        o_cx    = n_cx;
        o_cy    = n_cy;
        o_x     = n_x;
        o_y     = n_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_d      <= '0;
            r_active <= 1'b0;
        end else if (o_push) begin
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_x      <= n_x;
            r_y      <= n_y;
            r_d      <= n_d;
            r_active <= !o_done;
        end
    end

endmodule

// ===== rtl/core/bcr_fifo.sv =====
// bcr_fifo: small register queue between front and back ends.
// Depends on bcr_pkg for its default depth.
module bcr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bcr_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_space,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [AW:0]      r_count;
    logic             do_push, do_pop;

    always_comb begin
        o_space = (r_count != (AW+1)'(DEPTH));
        o_valid = (r_count != '0);
        o_data  = r_mem[r_rptr];
        do_push = i_push && o_space;
        do_pop  = i_pop && o_valid;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH-1)) ? '0 : r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH-1)) ? '0 : r_rptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

endmodule

// ===== rtl/core/bcr_back.sv =====
// bcr_back: expands one position record into eight symmetric pixels.
// One pixel per cycle while i_ready is high, from registered record and octant counter.
// Depends on bcr_pkg.
module bcr_back #(
    parameter int RADIUS_BITS = bcr_pkg::RADIUS_BITS_DEF,
    parameter int COORD_BITS  = bcr_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    output logic                         o_q_pop,
    input  logic [COORD_BITS-1:0]        i_cx,
    input  logic [COORD_BITS-1:0]        i_cy,
    input  logic [RADIUS_BITS-1:0]       i_x,
    input  logic [RADIUS_BITS-1:0]       i_y,
    input  logic                         i_done,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [COORD_BITS+1:0] o_pixel_x,
    output logic signed [COORD_BITS+1:0] o_pixel_y,
    output logic [1:0]                   o_color,
    output logic                         o_last_of_step,
    output logic                         o_circle_done
);
    localparam int KW = $clog2(bcr_pkg::PIX_PER_POS);
    localparam int EW = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

    logic                   r_busy;
    logic [KW-1:0]          r_k;
    logic [COORD_BITS-1:0]  r_cx, r_cy;
    logic [RADIUS_BITS-1:0] r_x, r_y;
    logic                   r_done;

    logic                   last, load;
    logic [RADIUS_BITS-1:0] a, b;
    logic signed [EW-1:0]   cxe, cye, ae, be, px, py;

    always_comb begin
        last    = (r_k == KW'(bcr_pkg::PIX_PER_POS - 1));
        load    = !r_busy || (i_ready && last);
        o_q_pop = load && i_q_valid;
        a   = r_k[2] ? r_y : r_x;
        b   = r_k[2] ? r_x : r_y;
        cxe = $signed({{(EW-COORD_BITS){1'b0}}, r_cx});
        cye = $signed({{(EW-COORD_BITS){1'b0}}, r_cy});
        ae  = $signed({{(EW-RADIUS_BITS){1'b0}}, a});
        be  = $signed({{(EW-RADIUS_BITS){1'b0}}, b});
        px  = r_k[0] ? (cxe - ae) : (cxe + ae);
        py  = r_k[1] ? (cye + be) : (cye - be);
        o_valid        = r_busy;
        o_pixel_x      = px[COORD_BITS+1:0];
        o_pixel_y      = py[COORD_BITS+1:0];
        o_color        = bcr_pkg::COLOR_LUT[r_k];
        o_last_of_step = last;
        o_circle_done  = last && r_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (load) begin
            r_busy <= i_q_valid;
            r_k    <= '0;
        end else if (i_ready) begin
            r_k <= r_k + KW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cx   <= i_cx;
            r_cy   <= i_cy;
            r_x    <= i_x;
            r_y    <= i_y;
            r_done <= i_done;
        end
    end

endmodule

// ===== rtl/core/bresenham_circle_rasterizer.sv =====
// bresenham_circle_rasterizer: midpoint circle rasterizer, eight-way symmetry.
// Front end steps the circle, a two-entry queue feeds the pixel back end.
// A request's first pixel follows the queue and back-end record registers.
// Throughput: one request per cycle into the queue while it has space; pixels
// leave at one per cycle while i_ready is high, eight per request.
// Reset: synchronous active low; queue empty, no circle active, state zero.
module bresenham_circle_rasterizer #(
    parameter int RADIUS_BITS = bcr_pkg::RADIUS_BITS_DEF,
    parameter int COORD_BITS  = bcr_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_kind,
    input  logic [COORD_BITS-1:0]        i_center_x,
    input  logic [COORD_BITS-1:0]        i_center_y,
    input  logic [RADIUS_BITS-1:0]       i_radius,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [COORD_BITS+1:0] o_pixel_x,
    output logic signed [COORD_BITS+1:0] o_pixel_y,
    output logic [1:0]                   o_color,
    output logic                         o_last_of_step,
    output logic                         o_circle_done
);
    localparam int RW = 2 * COORD_BITS + 2 * RADIUS_BITS + 1;

    logic                   f_push, q_space, q_valid, q_pop;
    logic [COORD_BITS-1:0]  f_cx, f_cy, q_cx, q_cy;
    logic [RADIUS_BITS-1:0] f_x, f_y, q_x, q_y;
    logic                   f_done, q_done;
    logic [RW-1:0]          q_out;

    bcr_front #(
        .RADIUS_BITS(RADIUS_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_kind    (i_kind),
        .i_center_x(i_center_x),
        .i_center_y(i_center_y),
        .i_radius  (i_radius),
        .i_space   (q_space),
        .o_push    (f_push),
        .o_cx      (f_cx),
        .o_cy      (f_cy),
        .o_x       (f_x),
        .o_y       (f_y),
        .o_done    (f_done)
    );

    bcr_fifo #(
        .WIDTH(RW),
        .DEPTH(bcr_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (f_push),
        .i_data ({f_cx, f_cy, f_x, f_y, f_done}),
        .o_space(q_space),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_out)
    );

    assign {q_cx, q_cy, q_x, q_y, q_done} = q_out;

    bcr_back #(
        .RADIUS_BITS(RADIUS_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .o_q_pop       (q_pop),
        .i_cx          (q_cx),
        .i_cy          (q_cy),
        .i_x           (q_x),
        .i_y           (q_y),
        .i_done        (q_done),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_color       (o_color),
        .o_last_of_step(o_last_of_step),
        .o_circle_done (o_circle_done)
    );

    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_circle_done) |-> o_last_of_step)
        else $error("circle_done without last_of_step");

    a_last_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_step) |-> (o_color == bcr_pkg::COLOR_RED))
        else $error("eighth pixel has wrong color");

    a_idle_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && !o_valid) |=> o_valid)
        else $error("back end idle with queued record");

    a_start_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_kind == bcr_pkg::KIND_START)) |=> q_valid)
        else $error("start request not queued");

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for bresenham_circle_rasterizer.
// Drives start and advance requests, predicts all eight octant pixels per step
// and checks each pixel in order; needs bcr_pkg and the rasterizer RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int CB = bcr_pkg::COORD_BITS_DEF;
    localparam int RB = bcr_pkg::RADIUS_BITS_DEF;
    localparam int PB = bcr_pkg::COORD_BITS_DEF + 2;

    typedef struct packed {
        logic [PB-1:0] px;
        logic [PB-1:0] py;
        logic [1:0]    color;
        logic          last;
        logic          done;
    } t_pixel;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    logic          i_kind;
    logic [CB-1:0] i_center_x;
    logic [CB-1:0] i_center_y;
    logic [RB-1:0] i_radius;
    logic          o_valid;
    logic          i_ready;
    logic [PB-1:0] o_pixel_x;
    logic [PB-1:0] o_pixel_y;
    logic [1:0]    o_color;
    logic          o_last_of_step;
    logic          o_circle_done;

    bresenham_circle_rasterizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_radius       (i_radius),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_color        (o_color),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

    // Predictor state
    logic [CB-1:0]        circ_cx;
    logic [CB-1:0]        circ_cy;
    logic [RB-1:0]        circ_ox;
    logic [RB-1:0]        circ_oy;
    logic signed [13:0]   circ_dec;
    logic                 circle_live;

    t_pixel expected_pixels[$];
    t_pixel exp_pix;
    int     err_count;
    bit     tx_idle_on;
    bit     rx_idle_on;
    int     rx_stall_left;

    // octant order: sign of column term, sign of row term, swap, color
    int         oct_sa [8] = '{1, -1, 1, -1, 1, -1, 1, -1};
    int         oct_sb [8] = '{-1, -1, 1, 1, -1, -1, 1, 1};
    bit         oct_sw [8] = '{0, 0, 0, 0, 1, 1, 1, 1};
    logic [1:0] oct_col[8] = '{bcr_pkg::COLOR_WHITE, bcr_pkg::COLOR_GREEN,
                               bcr_pkg::COLOR_GREEN, bcr_pkg::COLOR_WHITE,
                               bcr_pkg::COLOR_RED,   bcr_pkg::COLOR_BLUE,
                               bcr_pkg::COLOR_BLUE,  bcr_pkg::COLOR_RED};

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(string what, logic [PB-1:0] got, logic [PB-1:0] want);
        err_count++;
        $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
    endtask

    task automatic emit_octants();
        int     a;
        int     b;
        int     px;
        int     py;
        bit     fin;
        t_pixel p;
        fin = (int'(circ_ox) + 1) > (int'(circ_oy) - ((circ_dec > 0) ? 1 : 0));
        for (int k = 0; k < 8; k++) begin
            a = oct_sw[k] ? int'(circ_oy) : int'(circ_ox);
            b = oct_sw[k] ? int'(circ_ox) : int'(circ_oy);
            px = int'(circ_cx) + oct_sa[k] * a;
            py = int'(circ_cy) + oct_sb[k] * b;
            p.px = px[PB-1:0];
            p.py = py[PB-1:0];
            p.color = oct_col[k];
            p.last = (k == 7);
            p.done = (k == 7) && fin;
            expected_pixels.push_back(p);
        end
        if (fin)
            circle_live = 1'b0;
    endtask

    task automatic rasterize_request(logic kind, logic [CB-1:0] cx, logic [CB-1:0] cy,
                                     logic [RB-1:0] r);
        if (kind == bcr_pkg::KIND_START) begin
            circ_cx = cx;
            circ_cy = cy;
            circ_ox = '0;
            circ_oy = r;
            circ_dec = 14'(bcr_pkg::DEC_INIT - 2 * int'(r));
            circle_live = 1'b1;
            emit_octants();
        end else if (circle_live) begin
            circ_ox = circ_ox + RB'(1);
            if (circ_dec > 0) begin
                circ_oy = circ_oy - RB'(1);
                circ_dec = 14'(int'(circ_dec) + 4 * (int'(circ_ox) - int'(circ_oy))
                               + bcr_pkg::DEC_DIAG);
            end else begin
                circ_dec = 14'(int'(circ_dec) + 4 * int'(circ_ox) + bcr_pkg::DEC_AXIAL);
            end
            emit_octants();
        end
    endtask

    task automatic send_request(logic kind, logic [CB-1:0] cx, logic [CB-1:0] cy,
                                logic [RB-1:0] r);
        int gap;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_center_x <= cx;
        i_center_y <= cy;
        i_radius   <= r;
        do @(posedge i_clk); while (!o_ready);
        rasterize_request(kind, cx, cy, r);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_pixels.size() != 0);
    endtask

    task automatic send_advance();
        send_request(bcr_pkg::KIND_ADVANCE, CB'($urandom), CB'($urandom), RB'($urandom));
    endtask

    task automatic run_to_done();
        while (circle_live)
            send_advance();
    endtask

    task automatic test_idle_advance();
        repeat (3) send_advance();
        wait_drained();
    endtask

    task automatic test_zero_radius();
        send_request(bcr_pkg::KIND_START, 11'd1000, 11'd24, '0);
        send_advance();
        send_request(bcr_pkg::KIND_START, '0, '1, '0);
        send_advance();
        wait_drained();
    endtask

    task automatic test_small_circles();
        for (int r = 1; r <= 4; r++) begin
            send_request(bcr_pkg::KIND_START, 11'd512, 11'd300, r[RB-1:0]);
            run_to_done();
            send_advance();
        end
        wait_drained();
    endtask

    task automatic test_extremes();
        send_request(bcr_pkg::KIND_START, '0, '0, '1);
        repeat (3) send_advance();
        // restart mid-circle
        send_request(bcr_pkg::KIND_START, '1, '1, '1);
        repeat (3) send_advance();
        send_request(bcr_pkg::KIND_START, '0, '1, 10'h2AA);
        send_advance();
        send_request(bcr_pkg::KIND_START, '1, '0, 10'h155);
        send_advance();
        wait_drained();
    endtask

    task automatic test_random_circles();
        int sent;
        int r;
        int pick;
        sent = 0;
        while (sent < 230) begin
            if (sent > 185) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                tx_idle_on = $urandom_range(0, 1);
                rx_idle_on = $urandom_range(0, 1);
            end
            pick = $urandom_range(0, 9);
            if (pick < 6)
                r = $urandom_range(0, 20);
            else if (pick < 8)
                r = $urandom_range(21, 90);
            else
                r = $urandom_range(0, 1023);
            send_request(bcr_pkg::KIND_START, CB'($urandom), CB'($urandom), r[RB-1:0]);
            sent++;
            while (circle_live && sent < 230) begin
                if ($urandom_range(0, 29) == 0)
                    break;
                send_advance();
                sent++;
            end
            if ($urandom_range(0, 3) == 0) begin
                if (circle_live)
                    sent++;
                send_advance();
            end
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
    endtask

    // receive side: random backpressure bursts
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            rx_stall_left <= 0;
            i_ready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            i_ready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rx_stall_left <= $urandom_range(0, 3);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected pixel x", o_pixel_x, '0);
            end else begin
                exp_pix = expected_pixels.pop_front();
                if (o_pixel_x !== exp_pix.px)
                    report_mismatch("pixel_x", o_pixel_x, exp_pix.px);
                if (o_pixel_y !== exp_pix.py)
                    report_mismatch("pixel_y", o_pixel_y, exp_pix.py);
                if (o_color !== exp_pix.color)
                    report_mismatch("color", PB'(o_color), PB'(exp_pix.color));
                if (o_last_of_step !== exp_pix.last)
                    report_mismatch("last_of_step", PB'(o_last_of_step), PB'(exp_pix.last));
                if (o_circle_done !== exp_pix.done)
                    report_mismatch("circle_done", PB'(o_circle_done), PB'(exp_pix.done));
            end
        end
    end

    initial begin
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        circ_cx       = '0;
        circ_cy       = '0;
        circ_ox       = '0;
        circ_oy       = '0;
        circ_dec      = '0;
        circle_live   = 1'b0;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_kind     <= bcr_pkg::KIND_START;
        i_center_x <= '0;
        i_center_y <= '0;
        i_radius   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_advance();
        test_zero_radius();
        test_small_circles();
        test_extremes();
        test_random_circles();

        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== bresenham_circle_rasterizer.f =====
rtl/core/bcr_pkg.sv
rtl/core/bcr_front.sv
rtl/core/bcr_fifo.sv
rtl/core/bcr_back.sv
rtl/core/bresenham_circle_rasterizer.sv
tb/testbench.sv
